// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file psev_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PSEV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define PSEV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/psev_pkg.sv =====
// ----------------------------------------------------------------------------
// psev_pkg
// Shared types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package psev_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUT_TDATA_W     = 40;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Special results
    localparam logic [DATA_W-1:0] DIV_ZERO_RESULT   = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] UNKNOWN_OP_RESULT = DATA_W'(9999);

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        KIND_SKIP,
        KIND_DIGIT,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_OTHER
    } kind_t;

    // One classified character as it travels from front to back
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
        logic       last;
    } item_t;

endpackage

// ===== rtl/psev_front.sv =====
// ----------------------------------------------------------------------------
// psev_front
// Accepts characters, classifies them and forwards them to the queue, dropping spaces that do not close an expression.
// ----------------------------------------------------------------------------
module psev_front
(
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] char_code
    input  logic             s_axis_tlast,
    input  logic             q_full,
    output logic             q_push,
    output psev_pkg::item_t  q_item
);

    psev_pkg::kind_t kind;
    logic [7:0]      digit_val;

    // Classify the character
    always_comb
    begin
        unique case (s_axis_tdata)
            psev_pkg::CHAR_SPACE: kind = psev_pkg::KIND_SKIP;
            psev_pkg::CHAR_PLUS:  kind = psev_pkg::KIND_ADD;
            psev_pkg::CHAR_MINUS: kind = psev_pkg::KIND_SUB;
            psev_pkg::CHAR_STAR:  kind = psev_pkg::KIND_MUL;
            psev_pkg::CHAR_SLASH: kind = psev_pkg::KIND_DIV;
            default:
            begin
                if (s_axis_tdata >= psev_pkg::CHAR_ZERO && s_axis_tdata <= psev_pkg::CHAR_NINE)
                    kind = psev_pkg::KIND_DIGIT;
                else
                    kind = psev_pkg::KIND_OTHER;
            end
        endcase
    end

    assign digit_val = s_axis_tdata - psev_pkg::CHAR_ZERO;

    // Drop spaces unless they close the expression
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full
                           && (kind != psev_pkg::KIND_SKIP || s_axis_tlast);
    assign q_item.kind   = kind;
    assign q_item.digit  = digit_val[3:0];
    assign q_item.last   = s_axis_tlast;

endmodule

// ===== rtl/psev_queue.sv =====
// ----------------------------------------------------------------------------
// psev_queue
// Short first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module psev_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  psev_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output psev_pkg::item_t  head_item
);

    localparam int PTR_W = (psev_pkg::QUEUE_DEPTH > 1) ? $clog2(psev_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(psev_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(psev_pkg::QUEUE_DEPTH - 1);

    psev_pkg::item_t  entry_reg [psev_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(psev_pkg::QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/psev_div.sv =====
// ----------------------------------------------------------------------------
// psev_div
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psev_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [psev_pkg::DATA_W-1:0] dividend,
    input  logic [psev_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [psev_pkg::DATA_W-1:0] quotient
);

    localparam int W     = psev_pkg::DATA_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [W:0]       rem_shift;
    logic [W:0]       diff;

    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    // Load magnitudes, then shift and subtract once per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            den_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Restore the sign
    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// ===== rtl/psev_back.sv =====
// ----------------------------------------------------------------------------
// psev_back
// Executes classified characters on the operand stack and emits results.
// ----------------------------------------------------------------------------
module psev_back
#(
    parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  psev_pkg::item_t                   q_item,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [psev_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [31:0] value,
                                                             // [33:32] status,
                                                             // [34] divided_by_zero
);

    localparam int W      = psev_pkg::DATA_W;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int PAD_W  = psev_pkg::OUT_TDATA_W - W - 3;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       err_reg, err_next;
    logic             dz_reg, dz_next;
    logic [W-1:0]     tos_reg, tos_next;
    psev_pkg::kind_t  kind_reg, kind_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_value_reg, out_value_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_dz_reg, out_dz_next;

    // Stack memory holds the entries below the top; the top lives in tos_reg
    logic [W-1:0]      stack_mem [STACK_DEPTH];
    logic [W-1:0]      rd_data_reg;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;

    logic          div_start, div_done;
    logic [W-1:0]  div_quot;
    logic [W-1:0]  mul_res;
    logic          empty;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign wr_addr = cnt_m1[ADDR_W-1:0];
    assign rd_addr = cnt_m2[ADDR_W-1:0];
    assign mul_res = rd_data_reg * tos_reg;
    assign empty   = (count_reg == '0);

    psev_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequence one item at a time
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        dz_next         = dz_reg;
        tos_next        = tos_reg;
        kind_next       = kind_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_dz_next     = out_dz_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        div_start       = 1'b0;

        // Drop the result once the sink takes it
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_item.kind;
                    last_next = q_item.last;
                    unique case (q_item.kind)
                        psev_pkg::KIND_SKIP:
                        begin
                        end
                        psev_pkg::KIND_DIGIT:
                        begin
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                if (err_reg == psev_pkg::ST_OK)
                                    err_next = psev_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = !empty;
                                tos_next   = W'(q_item.digit);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                if (err_reg == psev_pkg::ST_OK)
                                    err_next = psev_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_READ;
                            end
                        end
                    endcase
                    if (state_next == S_IDLE && q_item.last)
                        state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                count_next = cnt_m1;
                state_next = last_reg ? S_EMIT : S_IDLE;
                unique case (kind_reg)
                    psev_pkg::KIND_ADD: tos_next = rd_data_reg + tos_reg;
                    psev_pkg::KIND_SUB: tos_next = rd_data_reg - tos_reg;
                    psev_pkg::KIND_MUL: tos_next = mul_res;
                    psev_pkg::KIND_DIV:
                    begin
                        if (tos_reg == '0)
                        begin
                            tos_next = psev_pkg::DIV_ZERO_RESULT;
                            dz_next  = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            count_next = count_reg;
                            state_next = S_DIV;
                        end
                    end
                    default: tos_next = psev_pkg::UNKNOWN_OP_RESULT;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tos_next   = div_quot;
                    count_next = cnt_m1;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = empty ? '0 : tos_reg;
                    if (err_reg != psev_pkg::ST_OK)
                        out_status_next = err_reg;
                    else if (empty)
                        out_status_next = psev_pkg::ST_EMPTY;
                    else
                        out_status_next = psev_pkg::ST_OK;
                    out_dz_next = dz_reg;
                    count_next  = '0;
                    err_next    = psev_pkg::ST_OK;
                    dz_next     = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= psev_pkg::ST_OK;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            dz_reg        <= dz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        kind_reg       <= kind_next;
        last_reg       <= last_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_dz_reg     <= out_dz_next;
    end

    // Spill the old top on push, fetch the left operand on an operator
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= tos_reg;
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), out_dz_reg, out_status_reg, out_value_reg};

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates postfix expressions streamed one character per transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                   Marker
//  s_axis    in         tdata[7:0] char_code                      tlast end_of_expression
//  m_axis    out        tdata[31:0] value, [33:32] status,        -
//                       [34] divided_by_zero, [39:35] zero
//
//  Execution: a digit or a closing space is handled in S_IDLE (other spaces
//  drop at the front), an add, subtract, multiply or unknown operator also
//  in S_READ (stack read), a divide by nonzero in S_DIV (one quotient bit a cycle);
//  closing an expression adds S_EMIT to load the result register.
//  Reset: control state clears at once; stack memory needs no clearing pass.
//  Stalls: a two-entry queue takes characters while execution is busy until it
//  fills; the result register lets the next expression proceed until its own end.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
#(
    parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] char_code
    input  logic                              s_axis_tlast,   // end_of_expression
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [psev_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // [31:0] value,
                                                              // [33:32] status,
                                                              // [34] divided_by_zero
);

    logic            q_full, q_push, q_valid, q_pop;
    psev_pkg::item_t push_item, head_item;

    psev_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    psev_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    psev_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/psev_checker.sv =====
// ----------------------------------------------------------------------------
// psev_checker
// Port-level checks of the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psev_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [7:0]                        s_axis_tdata,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [psev_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // Hold a stalled result transaction
    `PSEV_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // An empty stack at the end reports zero
    `PSEV_ASSERT(a_empty_zero, m_axis_tvalid && m_axis_tdata[33:32] == psev_pkg::ST_EMPTY |-> m_axis_tdata[31:0] == 32'd0, "empty status with nonzero value")

    // No result right after reset
    `PSEV_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind postfix_stack_evaluator psev_checker u_psev_checker (.*);
